// ===== design/vfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants of the voxel face culling unit
// Command and direction codes, the input item and face records, the
// sequencer states and the register map.
// ----------------------------------------------------------------------------
package vfc_pkg;

	localparam int COORD_W    = 5;
	localparam int KIND_W     = 8;
	localparam int DIR_W      = 3;
	localparam int FACE_COUNT = 6;
	localparam int STEP_W     = 3;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// face direction codes, in emission order
	localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
	localparam logic [DIR_W-1:0] DIR_PY = 3'd1;
	localparam logic [DIR_W-1:0] DIR_NX = 3'd2;
	localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
	localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
	localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

	// lookup steps: the centre cell, then one step per direction
	localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd0;
	localparam logic [STEP_W-1:0] STEP_LAST   = 3'd6;

	// register index is paddr[2]
	localparam logic REG_AIR_CODE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_EMIT
	} vfc_state_t;

	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [KIND_W-1:0]  kind;
	} vfc_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [DIR_W-1:0]   dir;
		logic               last;
	} vfc_face_t;

endpackage

// ===== design/vfc_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_store: voxel block code memory
// Single-port synchronous RAM, one block code per cell, registered read.
// ----------------------------------------------------------------------------
module vfc_store
	import vfc_pkg::*;
#(
	parameter int AW = 15
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     addr,
	input  logic [KIND_W-1:0] wdata,
	output logic [KIND_W-1:0] rdata
);

	logic [KIND_W-1:0] mem [2**AW];
	logic [KIND_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/vfc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_seq: query sequencer and face output register
// Writes cells straight into the store, walks a query through the centre
// cell and its six neighbours, then emits the exposed faces one a cycle while the output is not held.
// ----------------------------------------------------------------------------
module vfc_seq
	import vfc_pkg::*;
#(
	parameter int GRID_SIZE = 32,
	parameter int AW        = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vfc_item_t         in_item,
	input  logic [KIND_W-1:0] air_code,
	output logic              mem_we,
	output logic [AW-1:0]     mem_addr,
	output logic [KIND_W-1:0] mem_wdata,
	input  logic [KIND_W-1:0] mem_rdata,
	output logic              out_valid,
	input  logic              out_ready,
	output vfc_face_t         out_face
);

	localparam int CW = AW / 3;
	localparam logic [6:0] GRID_LIM = 7'(GRID_SIZE);

	vfc_state_t state_q, state_d;

	logic [COORD_W-1:0]    cx_q, cy_q, cz_q;
	logic [STEP_W-1:0]     step_q;
	logic [STEP_W-1:0]     step_s1;
	logic                  rd_vld_s1;
	logic                  ingrid_s1;
	logic                  solid_q;
	logic [FACE_COUNT-1:0] exposed_q;
	logic                  out_valid_q;
	vfc_face_t             out_face_q;

	logic                  accept;
	logic                  in_ok;
	logic [6:0]            ix, iy, iz;
	logic [6:0]            nx, ny, nz;
	logic                  nb_in;
	logic [DIR_W-1:0]      dir_cur;
	logic [FACE_COUNT-1:0] pend;
	logic [DIR_W-1:0]      pick;
	logic [FACE_COUNT-1:0] pick_oh;
	logic [FACE_COUNT-1:0] rest;
	logic                  slot_free;
	logic                  load;

	// widen the item coordinates so any grid size can slice its address bits
	assign ix = {2'b00, in_item.x};
	assign iy = {2'b00, in_item.y};
	assign iz = {2'b00, in_item.z};

	assign accept = in_valid && in_ready;
	assign in_ok  = (ix < GRID_LIM) && (iy < GRID_LIM) && (iz < GRID_LIM);

	// neighbour coordinates for the current lookup step; -1 wraps far out of range
	assign dir_cur = step_q - 3'd1;
	always_comb begin
		nx = {2'b00, cx_q};
		ny = {2'b00, cy_q};
		nz = {2'b00, cz_q};
		if (step_q != STEP_CENTRE) begin
			case (dir_cur)
				DIR_PX:  nx = nx + 7'd1;
				DIR_PY:  ny = ny + 7'd1;
				DIR_NX:  nx = nx - 7'd1;
				DIR_NY:  ny = ny - 7'd1;
				DIR_PZ:  nz = nz + 7'd1;
				DIR_NZ:  nz = nz - 7'd1;
				default: nx = {2'b00, cx_q};
			endcase
		end
	end
	assign nb_in = (nx < GRID_LIM) && (ny < GRID_LIM) && (nz < GRID_LIM);

	// lowest pending face goes first
	assign pend = exposed_q & {FACE_COUNT{solid_q}};
	always_comb begin
		pick = DIR_PX;
		for (int i = FACE_COUNT - 1; i >= 0; i--) begin
			if (pend[i]) begin
				pick = DIR_W'(i);
			end
		end
	end
	assign pick_oh   = FACE_COUNT'(1) << pick;
	assign rest      = pend & ~pick_oh;
	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_ok && in_item.cmd == CMD_QUERY) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (step_q == STEP_LAST) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (pend == '0) begin
					state_d = ST_IDLE;
				end else if (load && rest == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = in_item.kind;
		mem_addr  = {iz[CW-1:0], iy[CW-1:0], ix[CW-1:0]};
		load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				mem_we   = in_valid && in_ok && in_item.cmd == CMD_WRITE;
			end
			ST_READ: begin
				mem_addr = {nz[CW-1:0], ny[CW-1:0], nx[CW-1:0]};
			end
			ST_WAIT: begin
				mem_addr = {nz[CW-1:0], ny[CW-1:0], nx[CW-1:0]};
			end
			ST_EMIT: begin
				load = (pend != '0) && slot_free;
			end
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= STEP_CENTRE;
			rd_vld_s1 <= 1'b0;
			solid_q   <= 1'b0;
			exposed_q <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_READ);
			if (state_q == ST_READ) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= STEP_CENTRE;
			end
			if (accept) begin
				exposed_q <= '0;
				solid_q   <= 1'b0;
			end else if (rd_vld_s1) begin
				if (step_s1 == STEP_CENTRE) begin
					solid_q <= (mem_rdata != air_code);
				end
				for (int i = 0; i < FACE_COUNT; i++) begin
					if (step_s1 == STEP_W'(i + 1)) begin
						exposed_q[i] <= !ingrid_s1 || (mem_rdata == air_code);
					end
				end
			end else if (load) begin
				exposed_q <= exposed_q & ~pick_oh;
			end
		end
	end

	// query coordinates and the lookup pipeline tag
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= in_item.x;
			cy_q <= in_item.y;
			cz_q <= in_item.z;
		end
		step_s1   <= step_q;
		ingrid_s1 <= nb_in;
	end

	// output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_face_q.x    <= cx_q;
			out_face_q.y    <= cy_q;
			out_face_q.z    <= cz_q;
			out_face_q.dir  <= pick;
			out_face_q.last <= (rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_face  = out_face_q;

	a_last_ends_query: assert property (@(posedge clk) disable iff (!arst_n)
		(load && rest == '0) |=> state_q == ST_IDLE)
		else $error("query did not finish after its last face");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> step_q <= STEP_LAST)
		else $error("lookup step ran past the last neighbour");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_face_q.dir <= DIR_NZ)
		else $error("face direction out of range");

	a_emit_after_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && $past(state_q) != ST_EMIT) |-> $past(state_q) == ST_WAIT)
		else $error("emission started before all neighbours were read");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !mem_we && !in_ready)
		else $error("store written or item taken during a query");

endmodule

// ===== design/voxel_face_culling_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culling_unit: face culling over a cubic grid of block codes
// Stores block codes per cell and lists the exposed faces of queried cells.
// ----------------------------------------------------------------------------
// A write beat stores its block code and gives no output. A query beat reads
// the cell and its six neighbours one after another through the single port
// of the block code memory, then emits one face per cycle while the output
// register is free or being drained. Input is taken only between items,
// which keeps writes and query reads of the memory apart. A face beat waits
// in an output register, so the next item is taken while it is held. The
// memory is not cleared: the user must write every cell before any query
// touches it; the block itself does not enforce this.
module voxel_face_culling_unit
	import vfc_pkg::*;
#(
	parameter int GRID_SIZE = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// item stream in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // cell_x, cell_y, cell_z, block_kind, pad
	input  logic                  s_axis_tuser,  // command
	// face stream out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // face_x, face_y, face_z, face_dir, pad
	output logic                  m_axis_tlast
);

	localparam int CW = $clog2(GRID_SIZE);
	localparam int AW = 3 * CW;

	logic [KIND_W-1:0] air_code_q;
	vfc_item_t         item;
	vfc_face_t         face;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [KIND_W-1:0] mem_wdata;
	logic [KIND_W-1:0] mem_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_code_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_AIR_CODE) begin
			air_code_q <= pwdata[KIND_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_AIR_CODE) ? {{(APB_DATA_W - KIND_W){1'b0}}, air_code_q}
		: '0;

	assign item.cmd  = s_axis_tuser;
	assign item.x    = s_axis_tdata[4:0];
	assign item.y    = s_axis_tdata[9:5];
	assign item.z    = s_axis_tdata[14:10];
	assign item.kind = s_axis_tdata[22:15];

	vfc_store #(
		.AW(AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	vfc_seq #(
		.GRID_SIZE(GRID_SIZE),
		.AW       (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (item),
		.air_code (air_code_q),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_face (face)
	);

	assign m_axis_tdata = {6'b000000, face.dir, face.z, face.y, face.x};
	assign m_axis_tlast = face.last;

endmodule

// ===== verif/voxel_face_culling_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culling_unit_tb: self-checking bench for the face culling unit
// Streams cell writes and face queries into the unit with random gaps on
// both sides. A local grid and air code track every accepted beat. Each
// face beat is checked field by field against the faces worked out for the
// query that caused it. The air code is changed between phases.
// ----------------------------------------------------------------------------
module voxel_face_culling_unit_tb;
	import vfc_pkg::*;

	localparam int GRID          = 32;
	localparam int CELLS         = GRID * GRID * GRID;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_ITEMS   = 100;
	localparam int MAX_REPORTS   = 10;

	localparam logic [APB_ADDR_W-1:0] AIR_CODE_ADDR   = {REG_AIR_CODE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = 3'h4;

	logic clk;
	logic arst_n = 1'b0;

	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;   // cell_x, cell_y, cell_z, block_kind, pad
	logic        s_axis_tuser  = 1'b0; // command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // face_x, face_y, face_z, face_dir, pad
	logic        m_axis_tlast;

	// stimulus side
	vfc_item_t item_queue[$];
	bit        cell_filled[CELLS];
	logic [KIND_W-1:0] phase_air;
	bit        calm;
	int        items_queued;

	// predictor side
	logic [KIND_W-1:0] grid_model[CELLS];
	logic [KIND_W-1:0] air_model;
	vfc_face_t         face_expect[$];
	vfc_item_t         drive_item;
	int                items_taken;
	int                writes_taken;
	int                queries_taken;
	int                faces_seen;
	int                mismatch_count;
	int                air_settings;
	int                send_gap;
	int                hold_left;

	voxel_face_culling_unit #(
		.GRID_SIZE(GRID)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int cell_index(int x, int y, int z);
		return (z * GRID + y) * GRID + x;
	endfunction

	function automatic bit in_grid(int x, int y, int z);
		return x >= 0 && x < GRID && y >= 0 && y < GRID && z >= 0 && z < GRID;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// a face is open where the neighbour is air or off the grid
	function automatic bit face_open(int x, int y, int z, logic [DIR_W-1:0] dir);
		int nx;
		int ny;
		int nz;
		nx = x;
		ny = y;
		nz = z;
		case (dir)
			DIR_PX: nx = x + 1;
			DIR_PY: ny = y + 1;
			DIR_NX: nx = x - 1;
			DIR_NY: ny = y - 1;
			DIR_PZ: nz = z + 1;
			default: nz = z - 1;
		endcase
		if (!in_grid(nx, ny, nz))
			return 1'b1;
		return grid_model[cell_index(nx, ny, nz)] == air_model;
	endfunction

	task automatic predict_faces(input vfc_item_t it);
		vfc_face_t        found[$];
		vfc_face_t        f;
		logic [DIR_W-1:0] dir;
		if (!in_grid(it.x, it.y, it.z))
			return;
		if (it.cmd == CMD_WRITE) begin
			grid_model[cell_index(it.x, it.y, it.z)] = it.kind;
			writes_taken++;
			return;
		end
		queries_taken++;
		if (grid_model[cell_index(it.x, it.y, it.z)] == air_model)
			return;
		for (int d = 0; d < FACE_COUNT; d++) begin
			dir = DIR_W'(d);
			if (face_open(it.x, it.y, it.z, dir)) begin
				f.x    = it.x;
				f.y    = it.y;
				f.z    = it.z;
				f.dir  = dir;
				f.last = 1'b0;
				found.push_back(f);
			end
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			face_expect.push_back(found[i]);
	endtask

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			flag_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	// feed beats from the pending queue, with a random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_faces(drive_item);
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (item_queue.size() > 0) begin
					drive_item = item_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, drive_item.kind, drive_item.z, drive_item.y,
						drive_item.x};
					s_axis_tuser <= drive_item.cmd;
					send_gap <= pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// take face beats and check them in order
	always @(posedge clk or negedge arst_n) begin
		vfc_face_t got;
		vfc_face_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				faces_seen++;
				got.x    = m_axis_tdata[4:0];
				got.y    = m_axis_tdata[9:5];
				got.z    = m_axis_tdata[14:10];
				got.dir  = m_axis_tdata[17:15];
				got.last = m_axis_tlast;
				if (face_expect.size() == 0) begin
					flag_mismatch($sformatf("unexpected face (%0d,%0d,%0d) dir %0d last %0d",
						got.x, got.y, got.z, got.dir, got.last));
				end else begin
					want = face_expect.pop_front();
					compare_field("face_x", got.x, want.x);
					compare_field("face_y", got.y, want.y);
					compare_field("face_z", got.z, want.z);
					compare_field("face_dir", got.dir, want.dir);
					compare_field("last_face", got.last, want.last);
				end
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else begin
				m_axis_tready <= 1'b1;
				hold_left <= pick_gap();
			end
		end
	end

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == AIR_CODE_ADDR)
			air_model = data[KIND_W-1:0];
	endtask

	task automatic set_air(input logic [KIND_W-1:0] code);
		apb_write(AIR_CODE_ADDR, {24'd0, code});
		phase_air = code;
		air_settings++;
	endtask

	task automatic queue_item(input logic cmd, input int x, input int y, input int z,
			input int kind);
		vfc_item_t it;
		it.cmd  = cmd;
		it.x    = COORD_W'(x);
		it.y    = COORD_W'(y);
		it.z    = COORD_W'(z);
		it.kind = KIND_W'(kind);
		if (cmd == CMD_WRITE)
			cell_filled[cell_index(x, y, z)] = 1'b1;
		item_queue.push_back(it);
		items_queued++;
	endtask

	function automatic int pick_kind(input bit solid);
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (solid && r < 85) begin
			do
				k = $urandom_range(0, 255);
			while (k == phase_air);
			return k;
		end
		if (r < 45)
			return phase_air;
		if (r < 55)
			return $urandom_range(0, 1) ? 255 : 0;
		return $urandom_range(0, 255);
	endfunction

	// cluster around a grid corner, the centre or the far edge, or anywhere
	function automatic int pick_coord();
		int base;
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 2))
				0: base = 0;
				1: base = GRID / 2 - 1;
				default: base = GRID - 3;
			endcase
			return base + $urandom_range(0, 2);
		end
		return $urandom_range(0, GRID - 1);
	endfunction

	task automatic fill_cell(input int x, input int y, input int z, input bit solid);
		if (in_grid(x, y, z) && !cell_filled[cell_index(x, y, z)])
			queue_item(CMD_WRITE, x, y, z, pick_kind(solid));
	endtask

	// write whatever the query will read that was never written, then query
	task automatic queue_query_filled(input int x, input int y, input int z);
		fill_cell(x, y, z, 1'b1);
		fill_cell(x + 1, y, z, 1'b0);
		fill_cell(x, y + 1, z, 1'b0);
		fill_cell(x - 1, y, z, 1'b0);
		fill_cell(x, y - 1, z, 1'b0);
		fill_cell(x, y, z + 1, 1'b0);
		fill_cell(x, y, z - 1, 1'b0);
		queue_item(CMD_QUERY, x, y, z, $urandom_range(0, 255));
	endtask

	task automatic queue_random(input int count);
		int stop_at;
		stop_at = items_queued + count;
		while (items_queued < stop_at) begin
			if ($urandom_range(0, 99) < 30)
				queue_item(CMD_WRITE, pick_coord(), pick_coord(), pick_coord(),
					pick_kind(1'b0));
			else
				queue_query_filled(pick_coord(), pick_coord(), pick_coord());
		end
	endtask

	task automatic wait_drained();
		while (item_queue.size() != 0 || items_taken != items_queued
				|| face_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		air_model = '0;
		phase_air = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_air(8'h00);
		// corner cell: air on +x and +z, grid edge on -x, -y, -z
		queue_item(CMD_WRITE, 0, 0, 0, 8'hFF);
		queue_item(CMD_WRITE, 1, 0, 0, 8'h00);
		queue_item(CMD_WRITE, 0, 1, 0, 8'h01);
		queue_item(CMD_WRITE, 0, 0, 1, 8'h00);
		queue_item(CMD_QUERY, 0, 0, 0, 8'hFF);
		// far corner: only the grid edge is exposed
		queue_item(CMD_WRITE, 31, 31, 31, 8'h80);
		queue_item(CMD_WRITE, 30, 31, 31, 8'h7F);
		queue_item(CMD_WRITE, 31, 30, 31, 8'hFE);
		queue_item(CMD_WRITE, 31, 31, 30, 8'h80);
		queue_item(CMD_QUERY, 31, 31, 31, 8'h00);
		// query of an air cell gives nothing
		queue_item(CMD_WRITE, 2, 0, 0, 8'h33);
		queue_item(CMD_WRITE, 1, 1, 0, 8'h44);
		queue_item(CMD_WRITE, 1, 0, 1, 8'h00);
		queue_item(CMD_QUERY, 1, 0, 0, 8'h5A);
		// fully buried cell, then open its top
		queue_item(CMD_WRITE, 16, 16, 16, 8'hC3);
		queue_item(CMD_WRITE, 17, 16, 16, 8'h01);
		queue_item(CMD_WRITE, 16, 17, 16, 8'h02);
		queue_item(CMD_WRITE, 15, 16, 16, 8'h04);
		queue_item(CMD_WRITE, 16, 15, 16, 8'h08);
		queue_item(CMD_WRITE, 16, 16, 17, 8'h10);
		queue_item(CMD_WRITE, 16, 16, 15, 8'h20);
		queue_item(CMD_QUERY, 16, 16, 16, 8'hA5);
		queue_item(CMD_WRITE, 16, 16, 17, 8'h00);
		queue_item(CMD_QUERY, 16, 16, 16, 8'h00);
		queue_random(PHASE_ITEMS);
		wait_drained();

		set_air(8'hFF);
		queue_random(PHASE_ITEMS);
		wait_drained();

		// the write to the unused register must leave the air code alone
		set_air(KIND_W'($urandom_range(1, 254)));
		apb_write(UNUSED_REG_ADDR, $urandom());
		calm = 1'b1;
		queue_random(PHASE_ITEMS);
		wait_drained();

		calm = 1'b0;
		set_air(KIND_W'($urandom_range(0, 255)));
		queue_random(PHASE_ITEMS + 6);
		wait_drained();

		$display("Sent %0d beats (%0d writes, %0d queries) under %0d air code settings;",
			items_taken, writes_taken, queries_taken, air_settings);
		$display("checked %0d face beats, %0d mismatches, %0d faces outstanding.",
			faces_seen, mismatch_count, face_expect.size());
		if (mismatch_count == 0 && face_expect.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
